FILE: rtl/lca_binary_lifting_defines.svh
// ---------------------------------------------------------------------------
// LCA binary lifting: shared assertion macros
// Implication and next-cycle checks used by the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_DEFINES_SVH
`define LCA_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LCABL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LCABL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lcabl_pkg.sv
// ---------------------------------------------------------------------------
// LCA binary lifting: package
// Sizes, codes, command and status bundles shared by all modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lcabl_pkg;

  localparam int NODE_LIMIT  = 1024;
  localparam int LIFT_LEVELS = 11;
  localparam int NODE_W      = $clog2(NODE_LIMIT);
  localparam int CNT_W       = NODE_W + 1;
  localparam int LVL_W       = $clog2(LIFT_LEVELS + 1);
  localparam int DEP_W       = NODE_W;
  localparam int CMP_W       = CNT_W + 1;
  localparam int TBL_DEPTH   = NODE_LIMIT * LIFT_LEVELS;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);

  localparam int ACT_W       = 2;
  localparam int STS_W       = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = STS_W;

  // Link value that means "no ancestor".
  localparam logic [CNT_W-1:0] NO_NODE = CNT_W'(NODE_LIMIT);

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STS_W-1:0] ST_NOBUILD = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD_WR,
    OP_BLD_INIT, OP_F_RD1, OP_F_RD2, OP_F_WR, OP_F_NEXT,
    OP_D_INIT, OP_D_START, OP_D_RD, OP_D_UPD, OP_D_WR, OP_BLD_DONE,
    OP_Q_RDA, OP_Q_RDB, OP_Q_SWAP, OP_K_DEC, OP_K_LOAD,
    OP_Q_L_RD, OP_Q_L_NEW, OP_Q_L_DEP, OP_Q_SETR,
    OP_Q_J_RDP, OP_Q_J_RDQ, OP_Q_J_UPD, OP_Q_F_RD, OP_Q_F_RES,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_OK, RES_RANGE, RES_NOBUILD, RES_ANC
  } res_t;

  typedef struct packed {
    dp_op_t op;
    res_t   res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             a_bad;
    logic             b_bad;
    logic             par_bad;
    logic             built;
    logic             lvl_done;
    logic             idx_done;
    logic             k_zero;
    logic             lift_go;
    logic             p_eq_q;
    logic             out_free;
  } dp_sts_t;

  // Flat table address of (node, level).
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                 input logic [LVL_W-1:0]  lvl);
    return TBL_AW'(node) * TBL_AW'(LIFT_LEVELS) + TBL_AW'(lvl);
  endfunction

  // Top lifting level: floor(log2 n), capped at LIFT_LEVELS-1, zero for n <= 1.
  function automatic logic [LVL_W-1:0] top_level(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) l = LVL_W'(b);
    end
    if (l > LVL_W'(LIFT_LEVELS - 1)) l = LVL_W'(LIFT_LEVELS - 1);
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lca_binary_lifting.sv
// ---------------------------------------------------------------------------
// LCA binary lifting: top level
// Lowest common ancestor of two tree nodes from a power-of-two ancestor table.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   in_      slave      tdata: node_a, node_b, parent_node; tuser: action, has_parent
//   out_     master     tdata: ancestor; tuser: status
//   cfg_     slave      data: node_count
//
// A build first fills the lifting levels and then the depths; every step
// waits on the single table read port. A query makes one table or depth
// read per step. Reset is synchronous and active low; both memories start
// undefined and need no clearing pass. One item is in work at a time; a new
// beat is taken as soon as the result sits in the output register, even
// while that result is stalled.
`default_nettype none

module lca_binary_lifting
  import lcabl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [9:0] node_a, [19:10] node_b, [29:20] parent_node, [31:30] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action, [2] has_parent
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [9:0] ancestor, [15:10] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic [OUT_TUSER_W-1:0]      out_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data
);

  ctrl_cmd_t         cmd;
  dp_sts_t           sts;
  logic [NODE_W-1:0] anc;

  // The count register can always take a write; the user must write only when idle (not enforced here).
  assign cfg_ready = 1'b1;

  lcabl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcabl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_tuser[ACT_W-1:0]),
    .in_node_a     (in_tdata[NODE_W-1:0]),
    .in_node_b     (in_tdata[2*NODE_W-1:NODE_W]),
    .in_parent     (in_tdata[3*NODE_W-1:2*NODE_W]),
    .in_has_parent (in_tuser[ACT_W]),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_count     (cfg_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_ancestor  (anc),
    .out_status    (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(anc);

endmodule

`default_nettype wire

FILE: rtl/lcabl_ctrl.sv
// ---------------------------------------------------------------------------
// LCA binary lifting: controller
// Sequences load, build and query items as one datapath command per cycle, waiting while the output is full.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lca_binary_lifting_defines.svh"

module lcabl_ctrl
  import lcabl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_F_CHK, S_F_RD2, S_F_WR,
    S_D_CHK, S_D_RD, S_D_UPD, S_D_WR,
    S_Q_RDB, S_Q_SWAP, S_L_CHK, S_L_NEW, S_L_DEP, S_Q_EQ,
    S_J_RDP, S_J_RDQ, S_J_UPD, S_Q_FRD, S_Q_FRES,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd.op    = OP_NONE;
    cmd.res   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        res_nxt   = RES_OK;
        case (sts.act)
          ACT_LOAD: begin
            if (sts.a_bad || sts.par_bad) begin
              res_nxt = RES_RANGE;
            end else begin
              cmd.op = OP_LOAD_WR;
            end
          end
          ACT_BUILD: begin
            cmd.op    = OP_BLD_INIT;
            state_nxt = S_F_CHK;
          end
          ACT_QUERY: begin
            if (sts.a_bad || sts.b_bad) begin
              res_nxt = RES_RANGE;
            end else if (!sts.built) begin
              res_nxt = RES_NOBUILD;
            end else begin
              cmd.op    = OP_Q_RDA;
              state_nxt = S_Q_RDB;
            end
          end
          default: ;
        endcase
      end
      S_F_CHK: begin
        if (sts.lvl_done) begin
          cmd.op    = OP_D_INIT;
          state_nxt = S_D_CHK;
        end else if (sts.idx_done) begin
          cmd.op = OP_F_NEXT;
        end else begin
          cmd.op    = OP_F_RD1;
          state_nxt = S_F_RD2;
        end
      end
      S_F_RD2: begin
        cmd.op    = OP_F_RD2;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        cmd.op    = OP_F_WR;
        state_nxt = S_F_CHK;
      end
      S_D_CHK: begin
        if (sts.idx_done) begin
          cmd.op    = OP_BLD_DONE;
          res_nxt   = RES_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_D_START;
          state_nxt = S_D_RD;
        end
      end
      S_D_RD: begin
        cmd.op    = OP_D_RD;
        state_nxt = S_D_UPD;
      end
      S_D_UPD: begin
        cmd.op    = OP_D_UPD;
        state_nxt = sts.k_zero ? S_D_WR : S_D_RD;
      end
      S_D_WR: begin
        cmd.op    = OP_D_WR;
        state_nxt = S_D_CHK;
      end
      S_Q_RDB: begin
        cmd.op    = OP_Q_RDB;
        state_nxt = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        cmd.op    = OP_Q_SWAP;
        state_nxt = S_L_CHK;
      end
      S_L_CHK: begin
        if (sts.lift_go) begin
          cmd.op    = OP_Q_L_RD;
          state_nxt = S_L_NEW;
        end else if (sts.k_zero) begin
          state_nxt = S_Q_EQ;
        end else begin
          cmd.op = OP_K_DEC;
        end
      end
      S_L_NEW: begin
        cmd.op    = OP_Q_L_NEW;
        state_nxt = S_L_DEP;
      end
      S_L_DEP: begin
        cmd.op    = OP_Q_L_DEP;
        state_nxt = sts.k_zero ? S_Q_EQ : S_L_CHK;
      end
      S_Q_EQ: begin
        if (sts.p_eq_q) begin
          cmd.op    = OP_Q_SETR;
          res_nxt   = RES_ANC;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_K_LOAD;
          state_nxt = S_J_RDP;
        end
      end
      S_J_RDP: begin
        cmd.op    = OP_Q_J_RDP;
        state_nxt = S_J_RDQ;
      end
      S_J_RDQ: begin
        cmd.op    = OP_Q_J_RDQ;
        state_nxt = S_J_UPD;
      end
      S_J_UPD: begin
        cmd.op    = OP_Q_J_UPD;
        state_nxt = sts.k_zero ? S_Q_FRD : S_J_RDP;
      end
      S_Q_FRD: begin
        cmd.op    = OP_Q_F_RD;
        state_nxt = S_Q_FRES;
      end
      S_Q_FRES: begin
        cmd.op    = OP_Q_F_RES;
        res_nxt   = RES_ANC;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  `LCABL_ASSERT_IMP(a_out_only_when_free, clk, rst_n, cmd.op == OP_OUT, sts.out_free, "result pushed into a full output register")
  `LCABL_ASSERT_NXT(a_capture_dispatch, clk, rst_n, in_valid && in_ready, state_r == S_DISP, "accepted beat not dispatched")

endmodule

`default_nettype wire

FILE: rtl/lcabl_dp.sv
// ---------------------------------------------------------------------------
// LCA binary lifting: datapath
// Ancestor table and depth memories, walk registers and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lca_binary_lifting_defines.svh"

module lcabl_dp
  import lcabl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctrl_cmd_t               cmd,
  output dp_sts_t                      sts,
  input  wire logic [ACT_W-1:0]        in_action,
  input  wire logic [NODE_W-1:0]       in_node_a,
  input  wire logic [NODE_W-1:0]       in_node_b,
  input  wire logic [NODE_W-1:0]       in_parent,
  input  wire logic                    in_has_parent,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_count,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [NODE_W-1:0]            out_ancestor,
  output logic [STS_W-1:0]             out_status
);

  logic [CNT_W-1:0] tbl_mem [TBL_DEPTH];
  logic [DEP_W-1:0] dep_mem [NODE_LIMIT];

  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [NODE_W-1:0] a_r, a_nxt, b_r, b_nxt, par_r, par_nxt;
  logic              hp_r, hp_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic              built_r, built_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [LVL_W-1:0]  j_r, j_nxt, k_r, k_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt, q_r, q_nxt, pu_r, pu_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [DEP_W-1:0]  dp_r, dp_nxt, dq_r, dq_nxt;
  logic              xv_r, xv_nxt;
  logic              ov_r, ov_nxt;
  logic [NODE_W-1:0] oa_r, oa_nxt;
  logic [STS_W-1:0]  os_r, os_nxt;

  logic [CNT_W-1:0]  tbl_rd_r;
  logic [DEP_W-1:0]  dep_rd_r;
  logic              tbl_re, tbl_we, dep_re, dep_we;
  logic [TBL_AW-1:0] tbl_raddr, tbl_waddr;
  logic [CNT_W-1:0]  tbl_wdata;
  logic [NODE_W-1:0] dep_raddr, dep_waddr;
  logic [DEP_W-1:0]  dep_wdata;

  logic              rd_ok, p_ok, q_ok;
  logic [LVL_W-1:0]  k_dec;
  logic [CNT_W-1:0]  n_m1, qu;

  assign rd_ok = tbl_rd_r < n_r;
  assign p_ok  = p_r < n_r;
  assign q_ok  = q_r < n_r;
  assign k_dec = (k_r == '0) ? k_r : LVL_W'(k_r - 1'b1);
  assign n_m1  = CNT_W'(n_r - 1'b1);
  assign qu    = (q_ok && rd_ok) ? tbl_rd_r : NO_NODE;

  always_comb begin
    sts.act      = act_r;
    sts.a_bad    = {1'b0, a_r} >= n_r;
    sts.b_bad    = {1'b0, b_r} >= n_r;
    sts.par_bad  = hp_r && ({1'b0, par_r} >= n_r);
    sts.built    = built_r;
    sts.lvl_done = j_r > lv_r;
    sts.idx_done = i_r >= n_r;
    sts.k_zero   = (k_r == '0);
    sts.lift_go  = p_ok && (CMP_W'(dp_r) >= CMP_W'(dq_r) + (CMP_W'(1) << k_r));
    sts.p_eq_q   = (p_r == q_r);
    sts.out_free = !ov_r || out_ready;
  end

  always_comb begin
    act_nxt = act_r;  a_nxt = a_r;  b_nxt = b_r;  par_nxt = par_r;  hp_nxt = hp_r;
    n_nxt = n_r;  lv_nxt = lv_r;  built_nxt = built_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;
    p_nxt = p_r;  q_nxt = q_r;  pu_nxt = pu_r;  r_nxt = r_r;  d_nxt = d_r;
    dp_nxt = dp_r;  dq_nxt = dq_r;  xv_nxt = xv_r;
    ov_nxt = ov_r && !out_ready;  oa_nxt = oa_r;  os_nxt = os_r;
    tbl_re = 1'b0;  tbl_raddr = '0;
    tbl_we = 1'b0;  tbl_waddr = '0;  tbl_wdata = '0;
    dep_re = 1'b0;  dep_raddr = '0;
    dep_we = 1'b0;  dep_waddr = '0;  dep_wdata = '0;

    if (cfg_we) begin
      n_nxt     = (cfg_count > CNT_W'(NODE_LIMIT)) ? CNT_W'(NODE_LIMIT) : cfg_count;
      lv_nxt    = top_level(n_nxt);
      built_nxt = 1'b0;
    end

    case (cmd.op)
      OP_CAPTURE: begin
        act_nxt = in_action;  a_nxt = in_node_a;  b_nxt = in_node_b;
        par_nxt = in_parent;  hp_nxt = in_has_parent;
      end
      OP_LOAD_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = tbl_addr(a_r, '0);
        tbl_wdata = hp_r ? CNT_W'(par_r) : NO_NODE;
        built_nxt = 1'b0;
      end
      OP_BLD_INIT: begin
        j_nxt = LVL_W'(1);
        i_nxt = '0;
      end
      OP_F_RD1: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(i_r[NODE_W-1:0], LVL_W'(j_r - 1'b1));
      end
      OP_F_RD2: begin
        xv_nxt    = rd_ok;
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(tbl_rd_r[NODE_W-1:0], LVL_W'(j_r - 1'b1));
      end
      OP_F_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = tbl_addr(i_r[NODE_W-1:0], j_r);
        tbl_wdata = (xv_r && rd_ok) ? tbl_rd_r : NO_NODE;
        i_nxt     = CNT_W'(i_r + 1'b1);
      end
      OP_F_NEXT: begin
        j_nxt = LVL_W'(j_r + 1'b1);
        i_nxt = '0;
      end
      OP_D_INIT: i_nxt = '0;
      OP_D_START: begin
        p_nxt = i_r;
        d_nxt = '0;
        k_nxt = lv_r;
      end
      OP_D_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(p_r[NODE_W-1:0], k_r);
      end
      OP_D_UPD: begin
        if (rd_ok) begin
          p_nxt = tbl_rd_r;
          d_nxt = CNT_W'(d_r + (CNT_W'(1) << k_r));
        end
        k_nxt = k_dec;
      end
      OP_D_WR: begin
        dep_we    = 1'b1;
        dep_waddr = i_r[NODE_W-1:0];
        dep_wdata = DEP_W'((d_r > n_m1) ? n_m1 : d_r);
        i_nxt     = CNT_W'(i_r + 1'b1);
      end
      OP_BLD_DONE: built_nxt = 1'b1;
      OP_Q_RDA: begin
        dep_re    = 1'b1;
        dep_raddr = a_r;
      end
      OP_Q_RDB: begin
        dp_nxt    = dep_rd_r;
        dep_re    = 1'b1;
        dep_raddr = b_r;
      end
      OP_Q_SWAP: begin
        if (dp_r < dep_rd_r) begin
          p_nxt  = CNT_W'(b_r);  q_nxt  = CNT_W'(a_r);
          dp_nxt = dep_rd_r;     dq_nxt = dp_r;
        end else begin
          p_nxt  = CNT_W'(a_r);  q_nxt  = CNT_W'(b_r);
          dq_nxt = dep_rd_r;
        end
        k_nxt = lv_r;
      end
      OP_K_DEC:  k_nxt = k_dec;
      OP_K_LOAD: k_nxt = lv_r;
      OP_Q_L_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(p_r[NODE_W-1:0], k_r);
      end
      OP_Q_L_NEW: begin
        p_nxt     = rd_ok ? tbl_rd_r : NO_NODE;
        xv_nxt    = rd_ok;
        dep_re    = 1'b1;
        dep_raddr = tbl_rd_r[NODE_W-1:0];
      end
      OP_Q_L_DEP: begin
        dp_nxt = xv_r ? dep_rd_r : '0;
        k_nxt  = k_dec;
      end
      OP_Q_SETR: r_nxt = p_r;
      OP_Q_J_RDP: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(p_r[NODE_W-1:0], k_r);
      end
      OP_Q_J_RDQ: begin
        pu_nxt    = (p_ok && rd_ok) ? tbl_rd_r : NO_NODE;
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(q_r[NODE_W-1:0], k_r);
      end
      OP_Q_J_UPD: begin
        if (pu_r < n_r && pu_r != qu) begin
          p_nxt = pu_r;
          q_nxt = qu;
        end
        k_nxt = k_dec;
      end
      OP_Q_F_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(p_r[NODE_W-1:0], '0);
      end
      OP_Q_F_RES: r_nxt = (p_ok && rd_ok) ? tbl_rd_r : NO_NODE;
      OP_OUT: begin
        ov_nxt = 1'b1;
        oa_nxt = '0;
        case (cmd.res)
          RES_OK:      os_nxt = ST_OK;
          RES_RANGE:   os_nxt = ST_RANGE;
          RES_NOBUILD: os_nxt = ST_NOBUILD;
          RES_ANC: begin
            if (r_r < n_r) begin
              oa_nxt = r_r[NODE_W-1:0];
              os_nxt = ST_OK;
            end else begin
              os_nxt = ST_RANGE;
            end
          end
          default: os_nxt = ST_OK;
        endcase
      end
      default: ;
    endcase
  end

  // Table and depth memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_raddr];
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    if (dep_re) dep_rd_r <= dep_mem[dep_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= CNT_W'(1);
      lv_r    <= '0;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      n_r     <= n_nxt;
      lv_r    <= lv_nxt;
      built_r <= built_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  par_r <= par_nxt;  hp_r <= hp_nxt;
    i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;
    p_r <= p_nxt;  q_r <= q_nxt;  pu_r <= pu_nxt;  r_r <= r_nxt;  d_r <= d_nxt;
    dp_r <= dp_nxt;  dq_r <= dq_nxt;  xv_r <= xv_nxt;
    oa_r <= oa_nxt;  os_r <= os_nxt;
  end

  assign out_valid    = ov_r;
  assign out_ancestor = oa_r;
  assign out_status   = os_r;

  `LCABL_ASSERT_IMP(a_depth_in_range, clk, rst_n, dep_we, CNT_W'(dep_wdata) < n_r,
                    "stored depth not below node count")
  `LCABL_ASSERT_NXT(a_lift_in_range, clk, rst_n, cmd.op == OP_Q_L_NEW,
                    p_r < n_r || p_r == NO_NODE, "lifted node out of range")

endmodule

`default_nettype wire
